### hdl/hrts_pkg.sv
// ----------------------------------------------------------------------------
// hrts_pkg
// Types and constants shared by the remaining-time scheduler modules.
// ----------------------------------------------------------------------------
package hrts_pkg;

    localparam logic [15:0] QUANTUM_RST = 16'd256;
    localparam logic [47:0] SUM_MAX     = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] TIME_MAX    = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_ACCEPT = 2'd0,
        ST_FULL   = 2'd1,
        ST_RUN    = 2'd2,
        ST_NONE   = 2'd3
    } t_status;

    typedef enum logic {
        REQ_ARRIVE   = 1'b0,
        REQ_DISPATCH = 1'b1
    } t_req_kind;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  proc_id;
        logic [31:0] arrival_time;
        logic [31:0] burst_length;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  run_pid;
        logic [15:0] slice_length;
        logic [31:0] now_time;
        logic        finished;
        logic [47:0] wait_sum;
        logic [47:0] turnaround_sum;
    } t_rsp;

    // one ready-table entry as stored in RAM
    typedef struct packed {
        logic [7:0]  pid;
        logic [31:0] arrival;
        logic [31:0] remaining;
        logic [31:0] last_run;
    } t_entry;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        t_alu_op     op;
        logic [47:0] a;
        logic [47:0] b;
    } t_alu_req;

endpackage

### hdl/hrts_ram.sv
// ----------------------------------------------------------------------------
// hrts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hrts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### hdl/hrts_alu.sv
// ----------------------------------------------------------------------------
// hrts_alu
// Shared 48-bit add/subtract unit; bit 48 is carry out or borrow.
// ----------------------------------------------------------------------------
module hrts_alu
    import hrts_pkg::*;
(
    input  t_alu_req    i_req,
    output logic [48:0] o_res
);

    always_comb begin
        case (i_req.op)
            ALU_ADD: o_res = {1'b0, i_req.a} + {1'b0, i_req.b};
            ALU_SUB: o_res = {1'b0, i_req.a} - {1'b0, i_req.b};
            default: o_res = '0;
        endcase
    end

endmodule

### hdl/highest_remaining_time_scheduler_top.sv
// ----------------------------------------------------------------------------
// highest_remaining_time_scheduler_top
// Preemptive longest-remaining-time-first ready table with one shared adder.
// ----------------------------------------------------------------------------
// Usage: pulse start with a request beat while busy is low. An arrival
// examines the slots in turn, from slot zero, to find the lowest free slot.
// A dispatch reads every slot of the entry RAM once, one at a time through
// the single RAM read port, to find the entry with the most remaining time,
// then steps the shared adder through the time, wait, slice and turnaround
// updates; the turnaround steps are skipped when the entry does not finish,
// and an empty table ends the dispatch after the scan. Exactly one result
// beat follows each request, shown on o_rsp for a single cycle with o_strobe
// high; the receiver cannot stall it and must take it then. busy is already
// low in that cycle. Write the quantum only while idle.
// ----------------------------------------------------------------------------
module highest_remaining_time_scheduler_top
    import hrts_pkg::*;
#(
    parameter int MAX_PROCS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    output logic        o_strobe,
    output t_rsp        o_rsp,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    localparam int IDX_W = $clog2(MAX_PROCS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PROCS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ARR,      // walk valid bits for the lowest free slot
        S_SCAN,     // issue RAM reads, compare previous read
        S_SCAN_END, // compare the last read
        S_JUMP,     // clock forward to arrival if behind
        S_WAIT_D,   // time waited since last run
        S_WAIT_A,   // accumulate wait
        S_SLICE,    // min(quantum, remaining)
        S_ADV,      // advance clock by slice
        S_REM,      // remaining -= slice
        S_TAT_D,    // turnaround if finished
        S_TAT_A,    // accumulate turnaround
        S_WB        // write entry back, emit result
    } t_state;

    t_state           r_state;
    t_req             r_req;
    logic [IDX_W-1:0] r_idx;
    logic             r_cmp_vld;
    logic [IDX_W-1:0] r_cmp_slot;
    logic             r_found;
    t_entry           r_best;
    logic [IDX_W-1:0] r_best_slot;
    logic [31:0]      r_cur;
    logic [47:0]      r_wait;
    logic [47:0]      r_tat;
    logic [47:0]      r_diff;
    logic [15:0]      r_slice;
    logic             r_fin;
    logic [15:0]      r_quantum;
    logic             r_valid [MAX_PROCS];

    // RAM port signals
    logic             n_we;
    logic [IDX_W-1:0] n_waddr;
    t_entry           n_wdata;
    t_entry           ram_q;

    t_alu_req         n_alu;
    logic [48:0]      alu_res;
    logic             borrow;
    logic             n_win;
    logic [15:0]      q_eff;
    logic [47:0]      n_diff;

    hrts_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_PROCS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (n_waddr),
        .i_wdata (n_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_q)
    );

    hrts_alu u_alu (
        .i_req (n_alu),
        .o_res (alu_res)
    );

    assign busy   = (r_state != S_IDLE);
    assign borrow = alu_res[48];
    assign q_eff  = (r_quantum == 16'd0) ? 16'd1 : r_quantum;
    assign n_diff = borrow ? 48'd0 : alu_res[47:0];

    // candidate beats best when {remaining, ~pid} is strictly larger;
    // equal keys keep the earlier (lower) slot
    assign n_win = (r_state == S_SCAN || r_state == S_SCAN_END) && r_cmp_vld &&
                   r_valid[r_cmp_slot] && (!r_found || borrow);

    // shared adder operand select
    always_comb begin
        n_alu = '{op: ALU_ADD, a: 48'd0, b: 48'd0};
        case (r_state)
            S_SCAN, S_SCAN_END: begin
                n_alu.op = ALU_SUB;
                n_alu.a  = {8'd0, r_best.remaining, ~r_best.pid};
                n_alu.b  = {8'd0, ram_q.remaining, ~ram_q.pid};
            end
            S_JUMP: begin
                n_alu.op = ALU_SUB;
                n_alu.a  = {16'd0, r_cur};
                n_alu.b  = {16'd0, r_best.arrival};
            end
            S_WAIT_D: begin
                n_alu.op = ALU_SUB;
                n_alu.a  = {16'd0, r_cur};
                n_alu.b  = {16'd0, r_best.last_run};
            end
            S_WAIT_A: begin
                n_alu.a = r_wait;
                n_alu.b = r_diff;
            end
            S_SLICE: begin
                n_alu.op = ALU_SUB;
                n_alu.a  = {16'd0, r_best.remaining};
                n_alu.b  = {32'd0, q_eff};
            end
            S_ADV: begin
                n_alu.a = {16'd0, r_cur};
                n_alu.b = {32'd0, r_slice};
            end
            S_REM: begin
                n_alu.op = ALU_SUB;
                n_alu.a  = {16'd0, r_best.remaining};
                n_alu.b  = {32'd0, r_slice};
            end
            S_TAT_D: begin
                n_alu.op = ALU_SUB;
                n_alu.a  = {16'd0, r_cur};
                n_alu.b  = {16'd0, r_best.arrival};
            end
            S_TAT_A: begin
                n_alu.a = r_tat;
                n_alu.b = r_diff;
            end
            default: begin
                n_alu.op = ALU_ADD;
            end
        endcase
    end

    // RAM write: new arrival or dispatch write-back
    always_comb begin
        n_we    = 1'b0;
        n_waddr = r_idx;
        n_wdata = '{pid:       r_req.proc_id,
                    arrival:   r_req.arrival_time,
                    remaining: r_req.burst_length,
                    last_run:  r_req.arrival_time};
        case (r_state)
            S_ARR: begin
                n_we = !r_valid[r_idx];
            end
            S_WB: begin
                n_we             = 1'b1;
                n_waddr          = r_best_slot;
                n_wdata          = r_best;
                n_wdata.last_run = r_cur;
            end
            default: begin
                n_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_cur     <= '0;
            r_wait    <= '0;
            r_tat     <= '0;
            r_fin     <= 1'b0;
            r_quantum <= QUANTUM_RST;
            o_strobe  <= 1'b0;
            for (int i = 0; i < MAX_PROCS; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            o_strobe <= 1'b0;
            if (i_cfg_we) begin
                r_quantum <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_req     <= i_req;
                        r_idx     <= '0;
                        r_cmp_vld <= 1'b0;
                        r_found   <= 1'b0;
                        r_fin     <= 1'b0;
                        r_state   <= (i_req.req_type == REQ_DISPATCH) ? S_SCAN : S_ARR;
                    end
                end
                S_ARR: begin
                    if (!r_valid[r_idx]) begin
                        r_valid[r_idx] <= 1'b1;
                        o_strobe       <= 1'b1;
                        o_rsp          <= '{status: ST_ACCEPT, run_pid: 8'd0,
                                            slice_length: 16'd0, now_time: r_cur,
                                            finished: 1'b0, wait_sum: r_wait,
                                            turnaround_sum: r_tat};
                        r_state        <= S_IDLE;
                    end else if (r_idx == LAST_IDX) begin
                        o_strobe <= 1'b1;
                        o_rsp    <= '{status: ST_FULL, run_pid: 8'd0,
                                      slice_length: 16'd0, now_time: r_cur,
                                      finished: 1'b0, wait_sum: r_wait,
                                      turnaround_sum: r_tat};
                        r_state  <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_SCAN: begin
                    if (n_win) begin
                        r_best      <= ram_q;
                        r_best_slot <= r_cmp_slot;
                        r_found     <= 1'b1;
                    end
                    r_cmp_vld  <= 1'b1;
                    r_cmp_slot <= r_idx;
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_SCAN_END;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_SCAN_END: begin
                    if (n_win) begin
                        r_best      <= ram_q;
                        r_best_slot <= r_cmp_slot;
                    end
                    if (r_found || n_win) begin
                        r_state <= S_JUMP;
                    end else begin
                        o_strobe <= 1'b1;
                        o_rsp    <= '{status: ST_NONE, run_pid: 8'd0,
                                      slice_length: 16'd0, now_time: r_cur,
                                      finished: 1'b0, wait_sum: r_wait,
                                      turnaround_sum: r_tat};
                        r_state  <= S_IDLE;
                    end
                end
                S_JUMP: begin
                    if (borrow) begin
                        r_cur <= r_best.arrival;
                    end
                    r_state <= S_WAIT_D;
                end
                S_WAIT_D: begin
                    r_diff  <= n_diff;
                    r_state <= S_WAIT_A;
                end
                S_WAIT_A: begin
                    r_wait  <= alu_res[48] ? SUM_MAX : alu_res[47:0];
                    r_state <= S_SLICE;
                end
                S_SLICE: begin
                    r_slice <= borrow ? r_best.remaining[15:0] : q_eff;
                    r_state <= S_ADV;
                end
                S_ADV: begin
                    r_cur   <= (|alu_res[48:32]) ? TIME_MAX : alu_res[31:0];
                    r_state <= S_REM;
                end
                S_REM: begin
                    r_best.remaining <= alu_res[31:0];
                    r_state          <= S_TAT_D;
                end
                S_TAT_D: begin
                    if (r_best.remaining == 32'd0) begin
                        r_fin   <= 1'b1;
                        r_diff  <= n_diff;
                        r_state <= S_TAT_A;
                    end else begin
                        r_state <= S_WB;
                    end
                end
                S_TAT_A: begin
                    r_tat   <= alu_res[48] ? SUM_MAX : alu_res[47:0];
                    r_state <= S_WB;
                end
                S_WB: begin
                    if (r_fin) begin
                        r_valid[r_best_slot] <= 1'b0;
                    end
                    o_strobe <= 1'b1;
                    o_rsp    <= '{status: ST_RUN, run_pid: r_best.pid,
                                  slice_length: r_slice, now_time: r_cur,
                                  finished: r_fin, wait_sum: r_wait,
                                  turnaround_sum: r_tat};
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // an accepted request always makes the sequencer busy in the following cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but sequencer not busy");

    // result beat is only emitted on return to idle
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result beat while sequencer busy");

    // completion is only reported for a run slice
    a_fin_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.finished) |-> (o_rsp.status == ST_RUN))
        else $error("finished flag on a non-dispatch beat");

    // a slice never exceeds the effective quantum
    a_slice_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.status == ST_RUN) |-> (o_rsp.slice_length <= q_eff))
        else $error("slice longer than quantum");
`endif

endmodule

### tb/sv/highest_remaining_time_scheduler_top_tb.sv
// ----------------------------------------------------------------------------
// highest_remaining_time_scheduler_top_tb
// Self-checking bench for the longest-remaining-time-first ready table.
// A short scripted run covers the reset state, extremes, ties, duplicate pids,
// zero bursts and early and late arrivals. Random phases then follow, each at
// its own quantum, and a tail drives the clock into saturation. Every result
// beat is checked field by field against its scripted expectation or an in-bench scheduler model.
// ----------------------------------------------------------------------------
module highest_remaining_time_scheduler_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hrts_pkg::*;

    localparam int NPROC    = 16;
    localparam int SETTLE   = NPROC + 24;   // worst dispatch latency plus margin
    localparam int PHASE_SZ = 220;          // at least this many random beats per quantum phase

    // one scripted request; want is only meaningful when typed is set
    typedef struct packed {
        t_req  req;
        logic  typed;
        t_rsp  want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_req        req;
    logic        o_strobe;
    t_rsp        rsp;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    // scheduler model state
    logic        slot_used [NPROC];
    logic [7:0]  slot_pid  [NPROC];
    logic [31:0] slot_arr  [NPROC];
    logic [31:0] slot_left [NPROC];
    logic [31:0] slot_last [NPROC];
    logic [31:0] clk_now;
    logic [47:0] wait_acc;
    logic [47:0] tat_acc;
    logic [15:0] quantum_q;

    t_rsp rsp_due [$];      // results owed by the block, oldest first
    t_rsp head;
    t_row script [$];
    int   err_cnt;
    int   n_sent;
    bit   quiet;            // no sender gaps for the current stretch

    highest_remaining_time_scheduler_top #(
        .MAX_PROCS  (NPROC)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (req),
        .o_strobe   (o_strobe),
        .o_rsp      (rsp),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #(20_000_000);
        $display("highest_remaining_time_scheduler_top_tb failed");
        $finish;
    end

    function automatic logic [47:0] sat48(input logic [47:0] acc, input logic [47:0] add);
        logic [48:0] s;
        s = {1'b0, acc} + {1'b0, add};
        return s[48] ? SUM_MAX : s[47:0];
    endfunction

    // queue appends
    task automatic owe(input t_rsp x);
        rsp_due.insert(rsp_due.size(), x);
    endtask

    task automatic add_row(input t_row x);
        script.insert(script.size(), x);
    endtask

    // Applies one request to the model and returns the result it owes.
    function automatic t_rsp sched_step(input t_req r);
        t_rsp        o;
        int          pick;
        logic [31:0] qe;
        logic [31:0] cut;
        logic [32:0] t;
        o    = '0;
        pick = -1;
        if (r.req_type == REQ_ARRIVE) begin
            // lowest free slot
            for (int i = 0; i < NPROC; i++)
                if (!slot_used[i] && pick < 0) pick = i;
            if (pick < 0) begin
                o.status = ST_FULL;
            end else begin
                slot_used[pick] = 1'b1;
                slot_pid[pick]  = r.proc_id;
                slot_arr[pick]  = r.arrival_time;
                slot_left[pick] = r.burst_length;
                slot_last[pick] = r.arrival_time;
                o.status        = ST_ACCEPT;
            end
        end else begin
            // most remaining time; ties to lowest pid, then lowest slot
            for (int i = 0; i < NPROC; i++)
                if (slot_used[i] && (pick < 0 || slot_left[i] > slot_left[pick] ||
                    (slot_left[i] == slot_left[pick] && slot_pid[i] < slot_pid[pick])))
                    pick = i;
            if (pick < 0) begin
                o.status = ST_NONE;
            end else begin
                qe = (quantum_q == 16'd0) ? 32'd1 : {16'd0, quantum_q};
                o.status  = ST_RUN;
                o.run_pid = slot_pid[pick];
                if (clk_now < slot_arr[pick]) clk_now = slot_arr[pick];
                if (clk_now > slot_last[pick])
                    wait_acc = sat48(wait_acc, {16'd0, clk_now - slot_last[pick]});
                cut = (slot_left[pick] < qe) ? slot_left[pick] : qe;
                t   = {1'b0, clk_now} + {1'b0, cut};
                clk_now = t[32] ? TIME_MAX : t[31:0];
                slot_left[pick] = slot_left[pick] - cut;
                slot_last[pick] = clk_now;
                o.slice_length  = cut[15:0];
                if (slot_left[pick] == 32'd0) begin
                    o.finished = 1'b1;
                    if (clk_now > slot_arr[pick])
                        tat_acc = sat48(tat_acc, {16'd0, clk_now - slot_arr[pick]});
                    slot_used[pick] = 1'b0;
                end
            end
        end
        o.now_time       = clk_now;
        o.wait_sum       = wait_acc;
        o.turnaround_sum = tat_acc;
        return o;
    endfunction

    function automatic int live_cnt();
        int n;
        n = 0;
        for (int i = 0; i < NPROC; i++)
            if (slot_used[i]) n++;
        return n;
    endfunction

    function automatic t_req mk_req(input t_req_kind k, input logic [7:0] pid,
                                    input logic [31:0] arr, input logic [31:0] bl);
        t_req r;
        r.req_type     = k;
        r.proc_id      = pid;
        r.arrival_time = arr;
        r.burst_length = bl;
        return r;
    endfunction

    function automatic t_rsp mk_rsp(input t_status st, input logic [7:0] pid,
                                    input logic [15:0] sl, input logic [31:0] now,
                                    input logic fin, input logic [47:0] ws,
                                    input logic [47:0] ts);
        t_rsp o;
        o.status         = st;
        o.run_pid        = pid;
        o.slice_length   = sl;
        o.now_time       = now;
        o.finished       = fin;
        o.wait_sum       = ws;
        o.turnaround_sum = ts;
        return o;
    endfunction

    function automatic t_row mk_row(input t_req r, input logic typed, input t_rsp w);
        t_row x;
        x.req   = r;
        x.typed = typed;
        x.want  = w;
        return x;
    endfunction

    // Arrival near the model clock: on time, a little early, or late.
    // Bursts are whole quanta plus an optional fraction so ties come often.
    function automatic t_req rand_arrival();
        logic [7:0]  pid;
        logic [31:0] arr;
        logic [31:0] qe;
        logic [31:0] back;
        logic [31:0] bl;
        qe   = (quantum_q == 16'd0) ? 32'd1 : {16'd0, quantum_q};
        pid  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
        back = (clk_now < 32'h4000) ? clk_now : 32'h4000;
        case ($urandom_range(0, 3))
            0: arr = clk_now;
            1: arr = clk_now + $urandom_range(1, 32'h300);
            default: arr = clk_now - $urandom_range(back, 0);
        endcase
        bl = $urandom_range(0, 6) * qe;
        if ($urandom_range(0, 1) == 1) bl = bl + $urandom_range(qe - 1, 0);
        return mk_req(REQ_ARRIVE, pid, arr, bl);
    endfunction

    // The extra fields of a dispatch are don't-care; fill them anyway.
    function automatic t_req rand_dispatch();
        return mk_req(REQ_DISPATCH, 8'($urandom), $urandom, $urandom);
    endfunction

    task automatic diff(input string fld, input logic [47:0] e, input logic [47:0] a);
        if (a !== e) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, fld, e, a);
        end
    endtask

    // Presents one request beat and returns just after the edge that takes it.
    task automatic send(input t_req r, input logic typed, input t_rsp w);
        int   gap;
        t_rsp p;
        gap = quiet ? 0 : $urandom_range(0, 6);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        req   <= r;
        do @(posedge i_clk); while (busy);
        p = sched_step(r);
        owe(typed ? w : p);
        n_sent++;
    endtask

    // Hold off until every result is in, then load a new quantum.
    task automatic set_quantum(input logic [15:0] q);
        @(negedge i_clk);
        start <= 1'b0;
        while (rsp_due.size() != 0) @(posedge i_clk);
        repeat (3) @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= q;
        quantum_q  = q;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // Dispatch until the table is empty so the next quantum starts clean.
    task automatic drain();
        while (live_cnt() > 0) send(rand_dispatch(), 1'b0, '0);
    endtask

    // Result checker: every strobe must match the oldest owed result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (rsp_due.size() == 0) begin
                err_cnt++;
                $display("%0t: result beat with none expected, got %h", $time, rsp);
            end else begin
                head = rsp_due.pop_front();
                diff("status",         48'(head.status),       48'(rsp.status));
                diff("run_pid",        48'(head.run_pid),      48'(rsp.run_pid));
                diff("slice_length",   48'(head.slice_length), 48'(rsp.slice_length));
                diff("now_time",       48'(head.now_time),     48'(rsp.now_time));
                diff("finished",       48'(head.finished),     48'(rsp.finished));
                diff("wait_sum",       head.wait_sum,          rsp.wait_sum);
                diff("turnaround_sum", head.turnaround_sum,    rsp.turnaround_sum);
            end
        end
    end

    initial begin
        int          kind;
        int          len;
        int          target;
        logic [15:0] phase_q [6];
        start     = 1'b0;
        req       = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        i_rst_n   = 1'b0;
        quiet     = 1'b0;
        err_cnt   = 0;
        n_sent    = 0;
        for (int i = 0; i < NPROC; i++) begin
            slot_used[i] = 1'b0;
            slot_pid[i]  = '0;
            slot_arr[i]  = '0;
            slot_left[i] = '0;
            slot_last[i] = '0;
        end
        clk_now   = '0;
        wait_acc  = '0;
        tat_acc   = '0;
        quantum_q = QUANTUM_RST;

        // scripted part, reset quantum QUANTUM_RST
        // empty table right after reset
        add_row(mk_row(mk_req(REQ_DISPATCH, 8'd0, 32'd0, 32'd0), 1'b1,
                       mk_rsp(ST_NONE, 8'd0, 16'd0, 32'd0, 1'b0, 48'd0, 48'd0)));
        // zero burst: accepted, then runs a zero slice and finishes at once
        add_row(mk_row(mk_req(REQ_ARRIVE, 8'd0, 32'd0, 32'd0), 1'b1,
                       mk_rsp(ST_ACCEPT, 8'd0, 16'd0, 32'd0, 1'b0, 48'd0, 48'd0)));
        add_row(mk_row(mk_req(REQ_DISPATCH, 8'd0, 32'd0, 32'd0), 1'b1,
                       mk_rsp(ST_RUN, 8'd0, 16'd0, 32'd0, 1'b1, 48'd0, 48'd0)));
        // early arrivals with equal bursts: pid 7 beats 255, duplicate 7 by slot
        add_row(mk_row(mk_req(REQ_ARRIVE, 8'd255, 32'h100, 32'h300), 1'b1,
                       mk_rsp(ST_ACCEPT, 8'd0, 16'd0, 32'd0, 1'b0, 48'd0, 48'd0)));
        add_row(mk_row(mk_req(REQ_ARRIVE, 8'd7, 32'h100, 32'h300), 1'b1,
                       mk_rsp(ST_ACCEPT, 8'd0, 16'd0, 32'd0, 1'b0, 48'd0, 48'd0)));
        add_row(mk_row(mk_req(REQ_ARRIVE, 8'd7, 32'h100, 32'h300), 1'b1,
                       mk_rsp(ST_ACCEPT, 8'd0, 16'd0, 32'd0, 1'b0, 48'd0, 48'd0)));
        repeat (3) add_row(mk_row(rand_dispatch(), 1'b0, '0));
        // late arrival: wait counts from its own arrival time
        add_row(mk_row(mk_req(REQ_ARRIVE, 8'h80, 32'd0, 32'h10), 1'b0, '0));
        // early arrival well ahead: clock jumps when it is picked
        add_row(mk_row(mk_req(REQ_ARRIVE, 8'h3C, 32'h1000, 32'h2AA), 1'b0, '0));
        add_row(mk_row(mk_req(REQ_ARRIVE, 8'hAA, 32'h55, 32'h1FF), 1'b0, '0));
        repeat (12) add_row(mk_row(rand_dispatch(), 1'b0, '0));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[k]) send(script[k].req, script[k].typed, script[k].want);
        drain();

        // random phases, each with its own quantum; zero behaves as one
        phase_q = '{16'd1, 16'd0, 16'hFFFF, 16'($urandom_range(2, 65534)), 16'd77,
                    16'($urandom_range(2, 65534))};
        foreach (phase_q[p]) begin
            set_quantum(phase_q[p]);
            target = n_sent + PHASE_SZ;
            while (n_sent < target) begin
                kind  = $urandom_range(0, 2);
                quiet = ($urandom_range(0, 3) == 0);
                case (kind)
                    0: begin
                        // fill hard (often past full), then run slices
                        len = $urandom_range(1, 20);
                        repeat (len) send(rand_arrival(), 1'b0, '0);
                        len = $urandom_range(1, 30);
                        repeat (len) send(rand_dispatch(), 1'b0, '0);
                    end
                    1: begin
                        len = $urandom_range(5, 30);
                        repeat (len)
                            send(($urandom_range(0, 1) == 1) ? rand_arrival() : rand_dispatch(),
                                 1'b0, '0);
                    end
                    default: begin
                        len = $urandom_range(1, 40);
                        repeat (len) send(rand_dispatch(), 1'b0, '0);
                    end
                endcase
            end
            quiet = 1'b0;
            drain();
        end

        // tail: largest quantum, clock saturation, then full-range fields
        set_quantum(16'hFFFF);
        send(mk_req(REQ_ARRIVE, 8'd0, TIME_MAX, TIME_MAX), 1'b0, '0);
        repeat (3) send(rand_dispatch(), 1'b0, '0);
        repeat (40) begin
            if ($urandom_range(0, 2) == 0)
                send(rand_dispatch(), 1'b0, '0);
            else
                send(mk_req(REQ_ARRIVE, 8'($urandom), $urandom, $urandom), 1'b0, '0);
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (rsp_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("highest_remaining_time_scheduler_top_tb passed");
        end else begin
            $display("highest_remaining_time_scheduler_top_tb failed");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/hrts_pkg.sv
hdl/hrts_ram.sv
hdl/hrts_alu.sv
hdl/highest_remaining_time_scheduler_top.sv
tb/sv/highest_remaining_time_scheduler_top_tb.sv
